/* rtl/dhb_pkg.sv */
// Package for the diff hunk builder: payload structs, register indexes and
// shared constants. No dependencies; every other file in rtl/ uses it.
package dhb_pkg;

  localparam int unsigned MaxHunksDefault = 64;
  localparam int unsigned QueueDepth      = 4;

  localparam int unsigned RowW = 20;
  localparam int unsigned CntW = 21;
  localparam int unsigned CtxW = 16;
  localparam int unsigned CfgW = 21;

  localparam logic [CntW-1:0] DocMax = 21'h100000;
  localparam logic [CntW-1:0] CntMax = 21'h1FFFFF;

  localparam logic [15:0] ContextReset  = 16'd3;
  localparam logic [20:0] RowCountReset = 21'd0;

  // Configuration register indexes.
  typedef enum logic {
    CFG_CTX_SPAN = 1'b0,
    CFG_DOC_ROWS = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic            changed;
    logic [RowW-1:0] left_num;
    logic [RowW-1:0] right_num;
  } in_item_t;

  typedef struct packed {
    logic [RowW-1:0] span_first;
    logic [RowW-1:0] span_last;
    logic [CntW-1:0] change_cnt;
    logic [RowW-1:0] left_base;
    logic [RowW-1:0] right_base;
    logic            status;
    logic            last_of_run;
    logic            document_done;
  } result_t;

  // Up to two results produced by one row, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* rtl/dhb_hunk_core.sv */
// Hunk tracking core: configuration registers, document state and the
// per-row merge/emit decision. Depends on dhb_pkg.
module dhb_hunk_core #(
  parameter int unsigned MAX_HUNKS = dhb_pkg::MaxHunksDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [dhb_pkg::CfgW-1:0] cfg_data_i,
  input  logic                  fire_i,
  input  dhb_pkg::in_item_t     item_i,
  output dhb_pkg::push_t        push_o
);

  localparam int unsigned HuW = $clog2(MAX_HUNKS + 1);
  localparam int unsigned RW  = dhb_pkg::RowW;
  localparam int unsigned CW  = dhb_pkg::CntW;

  logic [dhb_pkg::CtxW-1:0] context_q;
  logic [CW-1:0]            doc_rows_q;

  logic [RW-1:0]  row_index_q, row_index_d;
  logic           hunk_open_q, hunk_open_d;
  logic [RW-1:0]  open_first_q, open_first_d;
  logic [RW-1:0]  open_last_q, open_last_d;
  logic [CW-1:0]  open_changed_q, open_changed_d;
  logic [RW-1:0]  open_left_q, open_left_d;
  logic [RW-1:0]  open_right_q, open_right_d;
  logic [HuW-1:0] hunks_used_q, hunks_used_d;
  logic           overflowed_q, overflowed_d;

  logic [CW-1:0] doc_len;
  logic [CW-1:0] end_row_w;
  logic [RW-1:0] end_row;
  logic          is_last;
  logic [RW-1:0] win_first;
  logic [CW-1:0] win_last_w;
  logic [RW-1:0] win_last;
  logic          touches;
  dhb_pkg::result_t hunk_res;
  dhb_pkg::result_t err_res;
  dhb_pkg::result_t flush_res;
  dhb_pkg::push_t   push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      context_q  <= dhb_pkg::ContextReset;
      doc_rows_q <= dhb_pkg::RowCountReset;
    end else if (cfg_we_i) begin
      case (dhb_pkg::cfg_index_e'(cfg_index_i))
        dhb_pkg::CFG_CTX_SPAN: context_q  <= cfg_data_i[dhb_pkg::CtxW-1:0];
        dhb_pkg::CFG_DOC_ROWS: doc_rows_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Document length is clamped to 1..DocMax; the last row is length - 1.
  always_comb begin
    if (doc_rows_q == '0) begin
      doc_len = CW'(1);
    end else if (doc_rows_q > dhb_pkg::DocMax) begin
      doc_len = dhb_pkg::DocMax;
    end else begin
      doc_len = doc_rows_q;
    end
    end_row_w = doc_len - CW'(1);
    end_row   = end_row_w[RW-1:0];
    is_last   = row_index_q >= end_row;

    if (row_index_q > RW'(context_q)) begin
      win_first = row_index_q - RW'(context_q);
    end else begin
      win_first = '0;
    end
    win_last_w = {1'b0, row_index_q} + CW'(context_q);
    if (win_last_w > {1'b0, end_row}) begin
      win_last = end_row;
    end else begin
      win_last = win_last_w[RW-1:0];
    end
    touches = {1'b0, win_first} <= ({1'b0, open_last_q} + CW'(1));
  end

  always_comb begin
    row_index_d    = row_index_q;
    hunk_open_d    = hunk_open_q;
    open_first_d   = open_first_q;
    open_last_d    = open_last_q;
    open_changed_d = open_changed_q;
    open_left_d    = open_left_q;
    open_right_d   = open_right_q;
    hunks_used_d   = hunks_used_q;
    overflowed_d   = overflowed_q;
    push           = '0;

    hunk_res            = '0;
    hunk_res.span_first = open_first_q;
    hunk_res.span_last  = open_last_q;
    hunk_res.change_cnt = open_changed_q;
    hunk_res.left_base  = open_left_q;
    hunk_res.right_base = open_right_q;

    err_res               = '0;
    err_res.status        = 1'b1;
    err_res.document_done = 1'b1;

    if (item_i.changed && !overflowed_q) begin
      if (hunk_open_q && touches) begin
        if (win_last > open_last_q) begin
          open_last_d = win_last;
        end
        if (open_changed_q != dhb_pkg::CntMax) begin
          open_changed_d = open_changed_q + CW'(1);
        end
      end else begin
        if (hunk_open_q) begin
          push.first  = hunk_res;
          push.count  = 2'd1;
          hunk_open_d = 1'b0;
        end
        if (hunks_used_q >= HuW'(MAX_HUNKS)) begin
          if (push.count == 2'd0) begin
            push.first = err_res;
          end else begin
            push.second = err_res;
          end
          push.count   = push.count + 2'd1;
          overflowed_d = 1'b1;
        end else begin
          hunks_used_d   = hunks_used_q + HuW'(1);
          hunk_open_d    = 1'b1;
          open_first_d   = win_first;
          open_last_d    = win_last;
          open_changed_d = CW'(1);
          open_left_d    = item_i.left_num;
          open_right_d   = item_i.right_num;
        end
      end
    end

    // The flush reports the hunk as it stands after this row's update.
    flush_res               = '0;
    flush_res.span_first    = open_first_d;
    flush_res.span_last     = open_last_d;
    flush_res.change_cnt    = open_changed_d;
    flush_res.left_base     = open_left_d;
    flush_res.right_base    = open_right_d;
    flush_res.document_done = 1'b1;

    if (is_last) begin
      if (hunk_open_d && !overflowed_d) begin
        if (push.count == 2'd0) begin
          push.first = flush_res;
        end else begin
          push.second = flush_res;
        end
        push.count = push.count + 2'd1;
      end
      row_index_d  = '0;
      hunk_open_d  = 1'b0;
      hunks_used_d = '0;
      overflowed_d = 1'b0;
    end else begin
      row_index_d = row_index_q + RW'(1);
    end

    if (push.count == 2'd1) begin
      push.first.last_of_run = 1'b1;
    end else if (push.count == 2'd2) begin
      push.second.last_of_run = 1'b1;
    end

    if (!fire_i) begin
      push.count = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_index_q    <= '0;
      hunk_open_q    <= 1'b0;
      open_first_q   <= '0;
      open_last_q    <= '0;
      open_changed_q <= '0;
      open_left_q    <= '0;
      open_right_q   <= '0;
      hunks_used_q   <= '0;
      overflowed_q   <= 1'b0;
    end else if (fire_i) begin
      row_index_q    <= row_index_d;
      hunk_open_q    <= hunk_open_d;
      open_first_q   <= open_first_d;
      open_last_q    <= open_last_d;
      open_changed_q <= open_changed_d;
      open_left_q    <= open_left_d;
      open_right_q   <= open_right_d;
      hunks_used_q   <= hunks_used_d;
      overflowed_q   <= overflowed_d;
    end
  end

endmodule

/* rtl/dhb_result_queue.sv */
// Result queue: a short shifting queue that takes up to two results per
// cycle and presents the oldest at its head. Depends on dhb_pkg.
module dhb_result_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dhb_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dhb_pkg::result_t out_data_o
);

  localparam int unsigned Depth = dhb_pkg::QueueDepth;
  localparam int unsigned QcW   = $clog2(Depth + 1);

  dhb_pkg::result_t entry_q [Depth];
  dhb_pkg::result_t entry_d [Depth];
  logic [QcW-1:0]   count_q, count_d;
  logic [QcW-1:0]   base;
  logic             pop;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = count_q != '0;
  assign out_data_o  = entry_q[0];
  // Room for a full two-result transaction, judged on the registered count.
  assign room_o      = count_q <= QcW'(Depth - 2);

  always_comb begin
    base = count_q - QcW'(pop);
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        entry_d[i] = entry_q[(i + 1) % Depth];
      end else begin
        entry_d[i] = entry_q[i];
      end
      if ((push_i.count != 2'd0) && (QcW'(i) == base)) begin
        entry_d[i] = push_i.first;
      end
      if ((push_i.count == 2'd2) && (QcW'(i) == base + QcW'(1))) begin
        entry_d[i] = push_i.second;
      end
    end
    count_d = base + QcW'(push_i.count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

endmodule

/* rtl/diff_hunk_builder_unit.sv */
// Top level of the diff hunk builder: input register, hunk core and result
// queue. Depends on dhb_pkg, dhb_hunk_core and dhb_result_queue.
//
// The block takes one diff row per cycle, numbering rows itself from zero,
// and reports hunks of changed rows widened by the configured context and
// merged when they touch. A row is registered on acceptance and processed
// once the result queue has room. One row yields up to two results, which
// enter a four-entry result queue that drains one result per cycle while the
// output is not stalled; the input stalls while a row waits in the input
// register and the queue has fewer than two free entries, so rows producing
// at most one result each sustain one row per cycle while the output is not
// stalled, and a row that closes one hunk and flushes or overflows another
// puts two results into the queue. Write the context and the document length
// registers only while the block is idle.
module diff_hunk_builder_unit #(
  parameter int unsigned MAX_HUNKS = dhb_pkg::MaxHunksDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  dhb_pkg::in_item_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output dhb_pkg::result_t         out_data_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [dhb_pkg::CfgW-1:0] cfg_data_i
);

  dhb_pkg::in_item_t item_q;
  logic              item_valid_q, item_valid_d;
  logic              room;
  logic              fire;
  logic              accept;
  dhb_pkg::push_t    push;

  assign fire       = item_valid_q && room;
  assign in_stall_o = item_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end else begin
      item_valid_d = item_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  dhb_hunk_core #(
    .MAX_HUNKS (MAX_HUNKS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .push_o      (push)
  );

  dhb_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
